@@ src/mlpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types, codes and default sizes for the multilevel priority FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpq_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int LEVELS_DEF    = 16;
    localparam int DEPTH_DEF     = 64;
    localparam int ITEM_BITS_DEF = 32;

    // Fixed field widths
    localparam int ITEM_W   = 32;
    localparam int PRI_W    = 5;
    localparam int LEVEL_W  = 4;
    localparam int CAP_W    = 7;
    localparam int STAT_W   = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Register indexes
    localparam logic REG_CAPACITY = 1'b0;

    // Request commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPRI = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the request fields
        logic exec;   // run the request against the level state
    } t_dp_cmd;

endpackage : mlpq_pkg

`default_nettype wire

@@ src/mlpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlpq_ctrl
// Request sequencer: capture, execute, then present the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpq_ctrl
    import mlpq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_stall,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule : mlpq_ctrl

`default_nettype wire

@@ src/mlpq_datapath.sv @@
// ----------------------------------------------------------------------------
// mlpq_datapath
// Per-level ring pointers and counts, shared entry memory, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpq_datapath
    import mlpq_pkg::*;
#(
    parameter int LEVELS    = LEVELS_DEF,
    parameter int DEPTH     = DEPTH_DEF,
    parameter int ITEM_BITS = ITEM_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [CAP_W-1:0]   i_capacity,
    input  wire logic               i_command,
    input  wire logic [PRI_W-1:0]   i_priority_req,
    input  wire logic [ITEM_W-1:0]  i_item,
    output logic [STAT_W-1:0]       o_status,
    output logic [ITEM_W-1:0]       o_item_out,
    output logic [LEVEL_W-1:0]      o_level_out
);

    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int STORE_BITS = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;
    localparam int ADDR_W     = LVL_W + PTR_W;
    localparam int MEM_DEPTH  = LEVELS * (2 ** PTR_W);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Captured request
    logic                  r_cmd;
    logic [PRI_W-1:0]      r_pri;
    logic [STORE_BITS-1:0] r_item;

    // Level state
    logic [CNT_W-1:0]      r_count [LEVELS];
    logic [PTR_W-1:0]      r_head  [LEVELS];
    logic [PTR_W-1:0]      r_tail  [LEVELS];
    logic [CAP_W-1:0]      r_total;

    // Entry memory, row per level
    logic [STORE_BITS-1:0] r_mem [MEM_DEPTH];

    // Result
    t_status               r_status;
    logic                  r_pop_ok;
    logic [LVL_W-1:0]      r_level;
    logic [STORE_BITS-1:0] r_rdata;

    logic                  is_push;
    logic                  bad_pri;
    logic                  full;
    logic                  push_ok;
    logic                  pop_ok;
    logic                  pop_any;
    logic [LVL_W-1:0]      push_lv;
    logic [LVL_W-1:0]      pop_lv;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    t_status               stat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_pri  <= i_priority_req;
            r_item <= i_item[STORE_BITS-1:0];
        end
    end

    // Lowest-numbered level that holds anything
    always_comb begin
        pop_any = 1'b0;
        pop_lv  = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                pop_any = 1'b1;
                pop_lv  = LVL_W'(i);
            end
        end
    end

    always_comb begin
        is_push = (r_cmd == CMD_PUSH);
        bad_pri = is_push && ((r_pri == '0) || (32'(r_pri) > 32'(LEVELS)));
        push_lv = LVL_W'(r_pri - 1'b1);
        full    = is_push && !bad_pri &&
                  ((r_total >= i_capacity) || (r_count[push_lv] >= CNT_W'(DEPTH)));
        push_ok = is_push && !bad_pri && !full;
        pop_ok  = !is_push && pop_any;
        waddr   = {push_lv, r_tail[push_lv]};
        raddr   = {pop_lv, r_head[pop_lv]};
        if (bad_pri) begin
            stat = STAT_BADPRI;
        end else if (full) begin
            stat = STAT_FULL;
        end else if (!is_push && !pop_any) begin
            stat = STAT_EMPTY;
        end else begin
            stat = STAT_OK;
        end
    end

    // Counts and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
            end
            r_total <= '0;
        end else if (i_cmd.exec) begin
            if (push_ok) begin
                r_tail[push_lv]  <= ring_next(r_tail[push_lv]);
                r_count[push_lv] <= r_count[push_lv] + 1'b1;
                r_total          <= r_total + 1'b1;
            end else if (pop_ok) begin
                r_head[pop_lv]   <= ring_next(r_head[pop_lv]);
                r_count[pop_lv]  <= r_count[pop_lv] - 1'b1;
                r_total          <= r_total - 1'b1;
            end
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && push_ok) begin
            r_mem[waddr] <= r_item;
        end
        if (i_cmd.exec && pop_ok) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= stat;
            r_pop_ok <= pop_ok;
            r_level  <= pop_ok ? pop_lv : '0;
        end
    end

    assign o_status    = r_status;
    assign o_item_out  = r_pop_ok ? ITEM_W'(r_rdata) : '0;
    assign o_level_out = LEVEL_W'(r_level);

endmodule : mlpq_datapath

`default_nettype wire

@@ src/multilevel_priority_fifo.sv @@
// ----------------------------------------------------------------------------
// multilevel_priority_fifo
// Strict-priority queue of LEVELS FIFO levels sharing one programmable
// capacity.
// ----------------------------------------------------------------------------
// Each request is either a push of an item handle at a one-based priority or
// a pop of the oldest handle of the lowest-numbered non-empty level, and each
// request produces exactly one result transfer carrying a status (ok, full,
// empty, bad priority), the popped handle and the zero-based level it came
// from. Requests are handled one at a time: each request passes through the
// capture, execute and present states, the popped handle coming from the
// registered read of the shared entry memory, and its result is held while
// the result side is stalled; the next request is taken once the result
// transfer completes.
// The capacity register sits at byte address 0 of the APB port and resets to
// 64; write it only while no request is in flight. Lowering it below the
// current fill keeps the held items poppable and refuses pushes until the
// fill drops below it. No clearing pass is needed after reset: each level's
// ring pointers and count reset to zero and only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_priority_fifo
    import mlpq_pkg::*;
#(
    parameter int LEVELS    = LEVELS_DEF,
    parameter int DEPTH     = DEPTH_DEF,
    parameter int ITEM_BITS = ITEM_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // Request channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_command,
    input  wire logic [PRI_W-1:0]   i_priority_req,
    input  wire logic [ITEM_W-1:0]  i_item,

    // Result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [STAT_W-1:0]       o_status,
    output logic [ITEM_W-1:0]       o_item_out,
    output logic [LEVEL_W-1:0]      o_level_out,

    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    t_dp_cmd          dp_cmd;
    logic [CAP_W-1:0] r_capacity;
    logic             cfg_wr;

    // Register index is the word address; a zero-wait-state port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // Read back capacity; any other address reads zero
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(r_capacity) : '0;

    // Sequencer: hold the request side stalled until the result transfer goes
    mlpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (dp_cmd)
    );

    // Level rings, counts and the shared entry memory
    mlpq_datapath #(
        .LEVELS    (LEVELS),
        .DEPTH     (DEPTH),
        .ITEM_BITS (ITEM_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_capacity     (r_capacity),
        .i_command      (i_command),
        .i_priority_req (i_priority_req),
        .i_item         (i_item),
        .o_status       (o_status),
        .o_item_out     (o_item_out),
        .o_level_out    (o_level_out)
    );

    // One request in flight: a presented result keeps the request side stalled
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result presented while request side open");

    // An accepted request shows its result once it has passed the execute state
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ##1 o_valid)
        else $error("result not presented after request transfer");

    // Anything but a successful operation returns no handle and level zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_OK)) |-> (o_item_out == '0 && o_level_out == '0))
        else $error("failed request returned a handle or level");

endmodule : multilevel_priority_fifo

`default_nettype wire
